// ===== src/button_event_detector_defines.svh =====
// Assertion macros for the button event detector.
// Included by the top level; no other dependencies.
`ifndef BUTTON_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_EVENT_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define BED_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_event_detector: assertion failed");
// Next-cycle implication, checked outside reset
`define BED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_event_detector: assertion failed");
`else
`define BED_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/bed_pkg.sv =====
// Shared types and constants for the button event detector.
// No dependencies; imported by every module of the block.
package bed_pkg;

  localparam int MaxEvents = 6;
  localparam int CountW    = 3;

  localparam logic [15:0] LongPressReset   = 16'd1000;
  localparam logic [15:0] RepeatReset      = 16'd200;
  localparam logic [15:0] DoubleClickReset = 16'd300;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_LONG  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    EV_PRESSED  = 4'd0,
    EV_CHANGED  = 4'd1,
    EV_PRESSING = 4'd2,
    EV_LONG     = 4'd3,
    EV_REPEAT   = 4'd4,
    EV_DOUBLE   = 4'd5,
    EV_LONG_REL = 4'd6,
    EV_SHORT    = 4'd7,
    EV_CLICKED  = 4'd8,
    EV_RELEASED = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_REPEAT       = 2'd1,
    CFG_DOUBLE_CLICK = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        pressed;
    logic [31:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [15:0] click_total;
    logic        last_event;
  } result_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
    logic [15:0] double_click_ms;
  } det_cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        long_latched;
    logic [31:0] press_stamp;
    logic [31:0] long_stamp;
    logic [31:0] release_stamp;
    logic [15:0] double_count;
  } det_state_t;

  typedef struct packed {
    logic [CountW-1:0]          count;
    logic [15:0]                click_total;
    event_t [MaxEvents-1:0]     code;
  } ev_list_t;

endpackage

// ===== src/bed_eval.sv =====
// Per-scan evaluation: next button state and the ordered event list.
// Depends on bed_pkg.
module bed_eval import bed_pkg::*; (
  input  det_state_t state,
  input  det_cfg_t   cfg,
  input  scan_t      scan,
  output det_state_t state_next,
  output ev_list_t   list
);

  logic        start;
  logic        active;
  logic [31:0] press_eff;
  logic [31:0] since_press;
  logic [31:0] since_long;
  logic [31:0] since_release;
  logic        long_hit;
  logic        repeat_hit;
  logic        double_hit;

  // Elapsed times, wrapping modulo 2^32
  assign start         = scan.pressed && (state.mode == MODE_IDLE);
  assign active        = start || (state.mode != MODE_IDLE);
  assign press_eff     = start ? scan.now_ms : state.press_stamp;
  assign since_press   = scan.now_ms - press_eff;
  assign since_long    = scan.now_ms - state.long_stamp;
  assign since_release = scan.now_ms - state.release_stamp;
  assign long_hit      = since_press >= {16'd0, cfg.long_press_ms};
  assign repeat_hit    = since_long >= {16'd0, cfg.repeat_ms};
  assign double_hit    = since_release < {16'd0, cfg.double_click_ms};

  // Next state
  always_comb begin
    state_next = state;
    if (start) begin
      state_next.mode        = MODE_PRESS;
      state_next.press_stamp = scan.now_ms;
    end
    if (active) begin
      if (scan.pressed) begin
        if (long_hit) begin
          state_next.mode = MODE_LONG;
          if (!state.long_latched) begin
            state_next.long_stamp   = scan.now_ms;
            state_next.long_latched = 1'b1;
          end else if (repeat_hit) begin
            state_next.long_stamp = scan.now_ms;
          end
        end
      end else begin
        state_next.mode          = MODE_IDLE;
        state_next.long_latched  = 1'b0;
        state_next.release_stamp = scan.now_ms;
        if (double_hit) begin
          state_next.double_count = state.double_count + 16'd1;
        end
      end
    end
  end

  // Event list, packed in emission order
  always_comb begin
    logic [CountW-1:0] n;
    n = '0;
    list.code = {MaxEvents{EV_PRESSED}};
    if (start) begin
      list.code[n] = EV_PRESSED;
      n = n + CountW'(1);
      list.code[n] = EV_CHANGED;
      n = n + CountW'(1);
    end
    if (active && scan.pressed) begin
      list.code[n] = EV_PRESSING;
      n = n + CountW'(1);
      if (long_hit && !state.long_latched) begin
        list.code[n] = EV_LONG;
        n = n + CountW'(1);
      end else if (long_hit && repeat_hit) begin
        list.code[n] = EV_REPEAT;
        n = n + CountW'(1);
      end
    end else if (active) begin
      if (double_hit) begin
        list.code[n] = EV_DOUBLE;
        n = n + CountW'(1);
      end
      if (state.long_latched) begin
        list.code[n] = EV_LONG_REL;
        n = n + CountW'(1);
      end
      if (!long_hit) begin
        list.code[n] = EV_SHORT;
        n = n + CountW'(1);
      end
      list.code[n] = EV_CLICKED;
      n = n + CountW'(1);
      list.code[n] = EV_RELEASED;
      n = n + CountW'(1);
      list.code[n] = EV_CHANGED;
      n = n + CountW'(1);
    end
    list.count       = n;
    list.click_total = state_next.double_count;
  end

endmodule

// ===== src/bed_emit.sv =====
// Result queue: holds one scan's event list and shifts out one beat a cycle while result_ready is high.
// Depends on bed_pkg.
module bed_emit import bed_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  ev_list_t list,
  output logic     free,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  event_t [MaxEvents-1:0] code;
  logic [CountW-1:0]      count;
  logic [15:0]            click;
  logic                   pop;

  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;
  assign free         = (count == '0) || ((count == CountW'(1)) && result_ready);

  assign result.event_res   = code[0];
  assign result.click_total = click;
  assign result.last_event  = (count == CountW'(1));

  // Track the number of beats left
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= list.count;
    end else if (pop) begin
      count <= count - CountW'(1);
    end
  end

  // Load a new list or advance to the next beat
  always_ff @(posedge clk) begin
    if (load) begin
      code  <= list.code;
      click <= list.click_total;
    end else if (pop) begin
      for (int i = 0; i < MaxEvents - 1; i++) begin
        code[i] <= code[i+1];
      end
    end
  end

endmodule

// ===== src/button_event_detector.sv =====
// Top level of the button event detector: scan register, config, state.
// Depends on bed_pkg, bed_eval, bed_emit and button_event_detector_defines.svh.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   scan     | scan_valid, scan_ready, scan      | in
//   result   | result_valid, result_ready, result| out
//   config   | cfg_we, cfg_index, cfg_data       | in
//
// A scan waits in the scan register until the result queue is free, then its events
// leave one beat per cycle while result_ready is high: 1 to 6 beats per scan.
// A scan with no events is dropped when it leaves the scan register.
// Reset clears mode, stamps and count and loads the default thresholds.
// A stalled result holds the queue; the scan register then fills and stalls.
`include "button_event_detector_defines.svh"
module button_event_detector import bed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        scan_valid,
  output logic        scan_ready,
  input  scan_t       scan,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  det_cfg_t   cfg;
  det_state_t state;
  det_state_t state_next;
  ev_list_t   list;
  scan_t      scan_q;
  logic       scan_held;
  logic       emit_free;
  logic       fire;

  assign fire       = scan_held && emit_free;
  assign scan_ready = !scan_held || emit_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms   <= LongPressReset;
      cfg.repeat_ms       <= RepeatReset;
      cfg.double_click_ms <= DoubleClickReset;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        CFG_REPEAT:       cfg.repeat_ms       <= cfg_data;
        CFG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted scan until it is evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_held <= 1'b0;
    end else if (scan_valid && scan_ready) begin
      scan_held <= 1'b1;
    end else if (fire) begin
      scan_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && scan_ready) begin
      scan_q <= scan;
    end
  end

  // Commit button state when a scan is evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= MODE_IDLE;
      state.long_latched  <= 1'b0;
      state.press_stamp   <= '0;
      state.long_stamp    <= '0;
      state.release_stamp <= '0;
      state.double_count  <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  bed_eval u_eval (
    .state      (state),
    .cfg        (cfg),
    .scan       (scan_q),
    .state_next (state_next),
    .list       (list)
  );

  bed_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .list         (list),
    .free         (emit_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A latched long press only exists in long-press mode
  `BED_ASSERT_IMPL(a_latch_mode, clk, rst, state.long_latched, state.mode == MODE_LONG)
  // A scan's events leave without a gap
  `BED_ASSERT_NEXT(a_no_gap, clk, rst, result_valid && result_ready && !result.last_event, result_valid)
  // The double-click count moves only when a scan is evaluated
  `BED_ASSERT_NEXT(a_count_hold, clk, rst, !fire, $stable(state.double_count))

endmodule
